// ----- rtl/core/rwrs_pkg.sv -----
// package for the reflecting random walk block
// shared constants, types and the quarter sine polynomial coefficients
package rwrs_pkg;
	localparam int ANGLE_BITS_DEF    = 16;
	localparam int POS_FRAC_BITS_DEF = 16;

	localparam logic [16:0] SIN_A = 17'd102944;
	localparam logic [16:0] SIN_B = 17'd42048;
	localparam logic [16:0] SIN_C = 17'd4640;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_SPEED  = 2'd2;
	localparam logic [1:0] REG_TURN   = 2'd3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// datapath operations issued by the controller
	localparam logic [3:0] OP_TURN  = 4'd0;
	localparam logic [3:0] OP_SD    = 4'd1;
	localparam logic [3:0] OP_Z2    = 4'd2;
	localparam logic [3:0] OP_T1    = 4'd3;
	localparam logic [3:0] OP_T2    = 4'd4;
	localparam logic [3:0] OP_T3    = 4'd5;
	localparam logic [3:0] OP_TRIG  = 4'd6;
	localparam logic [3:0] OP_MOVE  = 4'd7;
	localparam logic [3:0] OP_ROUND = 4'd8;
	localparam logic [3:0] OP_RFLX  = 4'd9;
	localparam logic [3:0] OP_RFLY  = 4'd10;
	localparam logic [3:0] OP_COMMIT = 4'd11;
	localparam logic [3:0] OP_LOAD  = 4'd12;
	localparam logic [3:0] OP_NONE  = 4'd15;

	typedef struct packed {
		logic [3:0] op;
		logic       use_sin; // 1: sine of heading, 0: cosine
		logic       axis_y;  // which coordinate the displacement goes to
	} rwrs_cmd_t;

	typedef struct packed {
		logic out_x; // candidate x outside its range
		logic out_y;
	} rwrs_stat_t;

	// input and output words
	typedef struct packed {
		logic [15:0] rand_frac;
		logic [23:0] time_step;
	} step_word_t;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [15:0] heading_out;
		logic [1:0]  bounced;
	} walk_word_t;
endpackage

// ----- rtl/core/rwrs_if.sv -----
// valid/ready channel interface for the walk block
// depends on nothing; payload type is a parameter
interface rwrs_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/rwrs_ctrl.sv -----
// controller sequencer for the walk block
// depends on rwrs_pkg
module rwrs_ctrl
	import rwrs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  rwrs_stat_t stat,
	output rwrs_cmd_t  cmd
);
	localparam logic [4:0] S_IDLE = 5'd0;
	// one trig evaluation: z2, t1, t2, t3, trig, move, round
	localparam logic [4:0] S_TURN = 5'd1;
	localparam logic [4:0] S_SD   = 5'd2;
	localparam logic [4:0] S_EV0  = 5'd3; // ..S_EV0+6
	localparam logic [4:0] S_CHK  = 5'd10;
	localparam logic [4:0] S_WAIT = 5'd11;

	logic [4:0] state_q;
	logic [1:0] pass_q; // 0 cos, 1 sin, 2 x redo, 3 y redo
	logic [2:0] ev;

	assign ev       = 3'(state_q - S_EV0);
	assign in_ready = (state_q == S_IDLE);

	// command decode
	always_comb begin
		cmd.op      = OP_NONE;
		cmd.use_sin = pass_q[0];
		cmd.axis_y  = pass_q[0];
		unique case (state_q)
			S_IDLE: cmd.op = (in_valid && in_ready) ? OP_LOAD : OP_NONE;
			S_TURN: cmd.op = OP_TURN;
			S_SD:   cmd.op = OP_SD;
			S_CHK:  cmd.op = OP_NONE;
			S_WAIT: cmd.op = OP_NONE;
			default: begin
				case (ev)
					3'd0: cmd.op = OP_Z2;
					3'd1: cmd.op = OP_T1;
					3'd2: cmd.op = OP_T2;
					3'd3: cmd.op = OP_T3;
					3'd4: cmd.op = OP_TRIG;
					3'd5: cmd.op = OP_MOVE;
					default: cmd.op = OP_ROUND;
				endcase
			end
		endcase
		// wall checks, then commit once the output register is free
		if (state_q == S_CHK) begin
			if (pass_q == 2'd0) cmd.op = OP_NONE;
			else if (pass_q == 2'd1 && stat.out_x) cmd.op = OP_RFLX;
			else if ((pass_q == 2'd1 || pass_q == 2'd2) && stat.out_y) cmd.op = OP_RFLY;
			else if (!out_valid || out_ready) cmd.op = OP_COMMIT;
			else cmd.op = OP_NONE;
		end
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q  <= 2'd0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) state_q <= S_TURN;
				S_TURN: state_q <= S_SD;
				S_SD: begin
					pass_q  <= 2'd0;
					state_q <= S_EV0;
				end
				S_CHK: begin
					if (pass_q == 2'd0) begin
						pass_q  <= 2'd1;
						state_q <= S_EV0;
					end else if (cmd.op == OP_RFLX) begin
						pass_q  <= 2'd2; // recompute x with cosine
						state_q <= S_EV0;
					end else if (cmd.op == OP_RFLY) begin
						pass_q  <= 2'd3;
						state_q <= S_EV0;
					end else if (cmd.op == OP_COMMIT) begin
						state_q <= S_IDLE;
					end
				end
				S_WAIT: state_q <= S_IDLE;
				default: state_q <= (ev == 3'd6) ? S_CHK : 5'(state_q + 5'd1);
			endcase
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.op == OP_COMMIT) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end
endmodule

// ----- rtl/core/rwrs_dp.sv -----
// datapath for the walk block: shared multiplier, position and heading state
// depends on rwrs_pkg
module rwrs_dp
	import rwrs_pkg::*;
#(
	parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
	parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  rwrs_cmd_t   cmd,
	input  logic [15:0] rand_frac,
	input  logic [23:0] time_step,
	input  logic [31:0] width_q,
	input  logic [31:0] height_q,
	input  logic [23:0] speed_q,
	input  logic [14:0] turn_q,
	output rwrs_stat_t  stat,
	output logic [31:0] pos_x,
	output logic [31:0] pos_y,
	output logic [15:0] heading_out,
	output logic [1:0]  bounced
);
	localparam int AB = ANGLE_BITS;
	localparam int PW = 50; // signed candidate coordinate width
	localparam logic [AB-1:0] QUART = AB'(1) << (AB - 2);
	localparam logic [AB-1:0] HALFT = AB'(1) << (AB - 1);

	logic [15:0]   r_q;
	logic [23:0]   dt_q;
	logic [31:0]   x_q, y_q;
	logic [AB-1:0] head_q, h_q;
	logic [31:0]   sd_q;
	logic [16:0]   z_q, z2_q, t_q;
	logic          neg_q;
	logic [55:0]   m_q;
	logic signed [PW-1:0] nx_q, ny_q;
	logic [1:0]    flags_q;

	// trig argument: sine or cosine of working heading
	logic [AB-1:0] harg;
	logic [AB-3:0] frac;
	logic [16:0]   zq, zsel;
	logic [1:0]    quad;
	assign harg = cmd.use_sin ? h_q : AB'(h_q + QUART);
	assign quad = harg[AB-1:AB-2];
	assign frac = harg[AB-3:0];
	assign zq   = 17'((64'(frac) << 24) >> (AB + 6));
	assign zsel = quad[0] ? 17'(17'd65536 - zq) : zq;

	// turn amount rounded to heading units
	logic [47:0] turn_a;
	logic [47:0] turn_r;
	assign turn_a = 48'(turn_q) * 48'(32'd65536 - 32'(r_q) * 32'd2);
	assign turn_r = (turn_a + (48'd1 << (31 - AB))) >> (32 - AB);

	// shared multiplier (at most 32x24)
	logic [31:0] mul_a;
	logic [23:0] mul_b;
	logic [55:0] prod;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SD:   begin mul_a = 32'(speed_q); mul_b = dt_q;         end
			OP_Z2:   begin mul_a = 32'(zsel);    mul_b = 24'(zsel);    end
			OP_T1:   begin mul_a = 32'(SIN_C);   mul_b = 24'(z2_q);    end
			OP_T2:   begin mul_a = 32'(t_q);     mul_b = 24'(z2_q);    end
			OP_TRIG: begin mul_a = 32'(t_q);     mul_b = 24'(z_q);     end
			OP_MOVE: begin mul_a = sd_q;         mul_b = 24'(t_q);     end
			default: ;
		endcase
	end
	assign prod = 56'(mul_a) * 56'(mul_b);

	// candidate coordinate from rounded move
	logic [55:0] mr;
	logic signed [PW-1:0] disp, cand, base;
	assign mr   = (m_q + (56'd1 << (31 - POS_FRAC_BITS))) >> (32 - POS_FRAC_BITS);
	assign disp = neg_q ? -PW'(mr) : PW'(mr);
	assign base = cmd.axis_y ? PW'(y_q) : PW'(x_q);
	assign cand = base + disp;

	assign stat.out_x = nx_q < 0 || nx_q > $signed(PW'(width_q));
	assign stat.out_y = ny_q < 0 || ny_q > $signed(PW'(height_q));

	function automatic logic [31:0] clampv(input logic signed [PW-1:0] v,
			input logic [31:0] w);
		if (v < 0) return 32'd0;
		if (v > $signed(PW'(w))) return w;
		return v[31:0];
	endfunction

	// control-bearing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q         <= '0;
			y_q         <= '0;
			head_q      <= '0;
			pos_x       <= '0;
			pos_y       <= '0;
			heading_out <= '0;
			bounced     <= '0;
		end else if (cmd.op == OP_COMMIT) begin
			x_q         <= clampv(nx_q, width_q);
			y_q         <= clampv(ny_q, height_q);
			head_q      <= h_q;
			pos_x       <= clampv(nx_q, width_q);
			pos_y       <= clampv(ny_q, height_q);
			heading_out <= 16'((64'(h_q) << 16) >> AB);
			bounced     <= flags_q;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin r_q <= rand_frac; dt_q <= time_step; flags_q <= 2'd0; end
			OP_TURN: h_q <= AB'(head_q + AB'(turn_r));
			OP_SD:   sd_q <= 32'(prod >> 16);
			OP_Z2: begin
				neg_q <= quad[1];
				z_q   <= zsel;
			end
			default: ;
		endcase
		case (cmd.op)
			OP_Z2:   z2_q <= 17'(prod >> 16);
			OP_T1:   t_q <= 17'(SIN_B - 17'(prod >> 16));
			OP_T2:   t_q <= 17'(prod >> 16);
			OP_T3:   t_q <= 17'(SIN_A - t_q);
			OP_TRIG: t_q <= 17'(prod >> 16);
			OP_MOVE: m_q <= prod;
			OP_ROUND: begin
				if (cmd.axis_y) ny_q <= cand; else nx_q <= cand;
			end
			OP_RFLX: begin h_q <= AB'(HALFT - h_q); flags_q[0] <= 1'b1; end
			OP_RFLY: begin h_q <= AB'(0 - h_q);     flags_q[1] <= 1'b1; end
			default: ;
		endcase
	end
endmodule

// ----- rtl/core/random_walk_reflect_step.sv -----
// Reflecting random walk step. Each input word (rand_frac, time_step) turns the
// heading, moves the walker, reflects off walls and returns one word with the
// new position, heading and bounce flags. Items are handled one at a time by a
// sequencer driving one shared multiplier: a turn and a speed-time setup step,
// then for each sine/cosine evaluation the steps z2, t1, t2, t3, trig, move,
// round and a wall check, two evaluations always plus one per wall hit. The
// next word can be taken as soon as the result word shows. A result word the
// receiver has not taken holds the next item at its final commit step.
// Configuration writes go straight to registers and must be made while
// idle.
module random_walk_reflect_step
	import rwrs_pkg::*;
#(
	parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
	parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	rwrs_if.sink                  in_ch,
	rwrs_if.source                out_ch
);
	logic [31:0] width_q, height_q;
	logic [23:0] speed_q;
	logic [14:0] turn_q;
	rwrs_cmd_t   cmd;
	rwrs_stat_t  stat;
	logic [31:0] px, py;
	logic [15:0] ho;
	logic [1:0]  bf;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 32'd65536000;
			height_q <= 32'd65536000;
			speed_q  <= 24'd65536;
			turn_q   <= 15'd4096;
		end else if (cfg_we && cfg_index[2] == 1'b0) begin
			unique case (cfg_index[1:0])
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_SPEED:  speed_q  <= cfg_data[23:0];
				REG_TURN:   turn_q   <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	rwrs_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid (in_ch.valid), .in_ready (in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat, .cmd
	);

	rwrs_dp #(.ANGLE_BITS(ANGLE_BITS), .POS_FRAC_BITS(POS_FRAC_BITS)) u_dp (
		.clk, .arst_n, .cmd,
		.rand_frac(in_ch.data.rand_frac), .time_step(in_ch.data.time_step),
		.width_q, .height_q, .speed_q, .turn_q, .stat,
		.pos_x(px), .pos_y(py), .heading_out(ho), .bounced(bf)
	);

	assign out_ch.data.pos_x       = px;
	assign out_ch.data.pos_y       = py;
	assign out_ch.data.heading_out = ho;
	assign out_ch.data.bounced     = bf;
endmodule

// ----- rtl/core/rwrs_chk.sv -----
// port-level checker for the walk block, bound to the top level
// depends on the top level ports only
module rwrs_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  bounced
);
	// one word at a time: no acceptance right after another
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("input taken while busy");
	// a result never appears right after acceptance
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid)) else $error("result too early");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(bounced))
		else $error("result dropped");
endmodule

bind random_walk_reflect_step rwrs_chk u_chk (
	.clk, .arst_n,
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.bounced(out_ch.data.bounced)
);
